FILE: hdl/lta_pkg.sv
// Shared types and helpers for the length-tagged Adler-32 frame checker.
// No dependencies; imported by lta_apb_regs and the top level.
`timescale 1ns / 1ps

package lta_pkg;

  localparam int unsigned LenW     = 27;
  localparam int unsigned TagLenW  = 3;
  localparam int unsigned WordW    = 32;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned AdlerW   = 16;
  localparam logic [AdlerW:0] AdlerMod = 17'd65521;

  localparam logic [LenW-1:0]    MinLenRst   = 27'd0;
  localparam logic [LenW-1:0]    MaxLenRst   = 27'd67108864;
  localparam logic [TagLenW-1:0] TagLenRst   = 3'd0;
  localparam logic [WordW-1:0]   TagValueRst = 32'd0;

  typedef struct packed {
    logic [LenW-1:0]    min_len;
    logic [LenW-1:0]    max_len;
    logic [TagLenW-1:0] tag_len;
    logic [WordW-1:0]   tag_value;
  } cfg_t;

  typedef struct packed {
    logic [AdlerW-1:0] low;
    logic [AdlerW-1:0] high;
  } adler_t;

  // One Adler-32 byte update; both sums stay below the modulus, so one
  // conditional subtract each is enough.
  function automatic adler_t adler_step(adler_t cur, logic [7:0] b);
    logic [AdlerW:0] lo_sum;
    logic [AdlerW:0] hi_sum;
    adler_t          res;
    lo_sum = {1'b0, cur.low} + {9'b0, b};
    if (lo_sum >= AdlerMod) begin
      lo_sum = lo_sum - AdlerMod;
    end
    res.low = lo_sum[AdlerW-1:0];
    hi_sum = {1'b0, cur.high} + {1'b0, res.low};
    if (hi_sum >= AdlerMod) begin
      hi_sum = hi_sum - AdlerMod;
    end
    res.high = hi_sum[AdlerW-1:0];
    return res;
  endfunction

endpackage

FILE: hdl/lta_apb_regs.sv
// APB-style configuration registers of the frame checker.
// Depends on lta_pkg (cfg_t, widths, reset values).
`timescale 1ns / 1ps

module lta_apb_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lta_pkg::AddrW-1:0] paddr,
  input  logic [lta_pkg::WordW-1:0] pwdata,
  output logic [lta_pkg::WordW-1:0] prdata,
  output logic                      pready,
  output lta_pkg::cfg_t             cfg_o
);
  import lta_pkg::*;

  typedef enum logic [1:0] {
    REG_MIN_LEN   = 2'd0,
    REG_MAX_LEN   = 2'd1,
    REG_TAG_LEN   = 2'd2,
    REG_TAG_VALUE = 2'd3
  } reg_idx_e;

  cfg_t       cfg_q;
  reg_idx_e   idx;
  logic       wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_len   <= MinLenRst;
      cfg_q.max_len   <= MaxLenRst;
      cfg_q.tag_len   <= TagLenRst;
      cfg_q.tag_value <= TagValueRst;
    end else if (wr_en) begin
      case (idx)
        REG_MIN_LEN:   cfg_q.min_len   <= pwdata[LenW-1:0];
        REG_MAX_LEN:   cfg_q.max_len   <= pwdata[LenW-1:0];
        REG_TAG_LEN:   cfg_q.tag_len   <= pwdata[TagLenW-1:0];
        REG_TAG_VALUE: cfg_q.tag_value <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_LEN:   prdata = {{(WordW-LenW){1'b0}}, cfg_q.min_len};
      REG_MAX_LEN:   prdata = {{(WordW-LenW){1'b0}}, cfg_q.max_len};
      REG_TAG_LEN:   prdata = {{(WordW-TagLenW){1'b0}}, cfg_q.tag_len};
      REG_TAG_VALUE: prdata = cfg_q.tag_value;
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: hdl/length_tag_adler_frame_checker_unit.sv
// Top level of the length-prefixed frame checker with Adler-32 check.
// Depends on lta_pkg and lta_apb_regs.
//
//   channel   dir  handshake               payload
//   in        in   in_valid_i/in_ready_o   in_byte_i
//   out       out  out_valid_o/out_ready_i out_kind_o data_byte_o status_o
//                                          last_o frame_length_o
//   cfg       in   psel/penable/pready     paddr pwdata pwrite, prdata back
//
// One byte per cycle sustained unless the output stalls; a byte waits in the
// input register, and any result goes to the output register as it leaves.
// The header/body state and Adler sums update in the cycle a byte leaves the
// input register; both Adler conditional subtracts sit in that one path.
// Reset puts the parser at the start of a header, clears all pipeline valids.
// An output stall holds the input register; in_ready_o drops only then.
// After an invalid length the block swallows every item until reset.
`timescale 1ns / 1ps

module length_tag_adler_frame_checker_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                in_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      out_kind_o,
  output logic [7:0]                data_byte_o,
  output logic [1:0]                status_o,
  output logic                      last_o,
  output logic [lta_pkg::WordW-1:0] frame_length_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lta_pkg::AddrW-1:0] paddr,
  input  logic [lta_pkg::WordW-1:0] pwdata,
  output logic [lta_pkg::WordW-1:0] prdata,
  output logic                      pready
);
  import lta_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_HALTED = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_CSUM    = 2'd2,
    ST_TAG     = 2'd3
  } status_e;

  cfg_t cfg;

  lta_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       advance;

  // frame state
  phase_e          phase_q, phase_d;
  logic [WordW-1:0] len_q, len_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  adler_t           adler_q, adler_d;
  logic             tag_ok_q, tag_ok_d;
  logic [WordW-1:0] rsum_q, rsum_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic             out_kind_q, out_kind_d;
  logic [7:0]       data_q, data_d;
  status_e          status_q, status_d;
  logic [WordW-1:0] flen_q, flen_d;
  logic             emit;

  // datapath helpers
  logic [TagLenW-1:0] tl;
  logic [WordW-1:0]   len_shift;
  logic [WordW-1:0]   data_end;
  logic [LenW:0]      idx_inc;
  logic               in_data;
  logic               in_tag;
  logic [TagLenW-1:0] tag_pos;
  logic [7:0]         tag_byte;
  adler_t             adler_upd;
  logic               frame_end;
  logic               len_bad;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= in_byte_i;
    end
  end

  // tag lengths above four act as four
  assign tl        = (cfg.tag_len > 3'd4) ? 3'd4 : cfg.tag_len;
  assign len_shift = {len_q[WordW-9:0], s1_byte_q};
  assign len_bad   = (len_shift > {{(WordW-LenW){1'b0}}, cfg.max_len})
                  || (len_shift < {{(WordW-LenW){1'b0}}, cfg.min_len})
                  || (len_shift < ({{(WordW-TagLenW){1'b0}}, tl} + WordW'(4)));
  assign data_end  = len_q - WordW'(4);
  assign idx_inc   = {1'b0, cnt_q} + {{LenW{1'b0}}, 1'b1};
  assign in_data   = {{(WordW-LenW){1'b0}}, cnt_q} < data_end;
  assign in_tag    = cnt_q < {{(LenW-TagLenW){1'b0}}, tl};
  // first tag byte sits in the highest used byte lane
  assign tag_pos   = tl - 3'd1 - cnt_q[TagLenW-1:0];
  assign tag_byte  = cfg.tag_value[tag_pos[1:0]*8 +: 8];
  assign adler_upd = adler_step(adler_q, s1_byte_q);
  assign frame_end = {{(WordW-LenW-1){1'b0}}, idx_inc} >= len_q;

  always_comb begin
    phase_d    = phase_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    adler_d    = adler_q;
    tag_ok_d   = tag_ok_q;
    rsum_d     = rsum_q;
    emit       = 1'b0;
    out_kind_d = 1'b0;
    data_d     = 8'd0;
    status_d   = ST_OK;
    flen_d     = len_q;

    case (phase_q)
      PH_HEADER: begin
        len_d  = len_shift;
        flen_d = len_shift;
        if (cnt_q[1:0] != 2'd3) begin
          cnt_d = cnt_q + LenW'(1);
        end else begin
          cnt_d = '0;
          if (len_bad) begin
            phase_d    = PH_HALTED;
            emit       = 1'b1;
            out_kind_d = 1'b1;
            status_d   = ST_BAD_LEN;
          end else begin
            phase_d = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (in_data) begin
          adler_d = adler_upd;
          if (in_tag) begin
            if (tag_byte != s1_byte_q) begin
              tag_ok_d = 1'b0;
            end
          end else begin
            emit   = 1'b1;
            data_d = s1_byte_q;
          end
        end else begin
          rsum_d = {rsum_q[WordW-9:0], s1_byte_q};
        end
        cnt_d = idx_inc[LenW-1:0];
        if (frame_end) begin
          emit       = 1'b1;
          out_kind_d = 1'b1;
          data_d     = 8'd0;
          if ({adler_d.high, adler_d.low} != rsum_d) begin
            status_d = ST_CSUM;
          end else if (!tag_ok_d) begin
            status_d = ST_TAG;
          end else begin
            status_d = ST_OK;
          end
          phase_d  = PH_HEADER;
          len_d    = '0;
          cnt_d    = '0;
          adler_d  = '{low: 16'd1, high: 16'd0};
          tag_ok_d = 1'b1;
          rsum_d   = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      len_q       <= '0;
      cnt_q       <= '0;
      adler_q     <= '{low: 16'd1, high: 16'd0};
      tag_ok_q    <= 1'b1;
      rsum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        phase_q  <= phase_d;
        len_q    <= len_d;
        cnt_q    <= cnt_d;
        adler_q  <= adler_d;
        tag_ok_q <= tag_ok_d;
        rsum_q   <= rsum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_kind_q <= out_kind_d;
      data_q     <= data_d;
      status_q   <= status_d;
      flen_q     <= flen_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_kind_q;
  assign data_byte_o    = data_q;
  assign status_o       = status_q;
  assign last_o         = out_kind_q;
  assign frame_length_o = flen_q;

endmodule

FILE: test/tb.sv
// Self-checking bench for length_tag_adler_frame_checker_unit: framed byte stream in,
// payload/status items out, checked against an in-bench frame parser with Adler-32.
// Depends on lta_pkg and the unit's RTL; drives the APB-style register port directly.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned RegMinLen   = 0;
  localparam int unsigned RegMaxLen   = 1;
  localparam int unsigned RegTagLen   = 2;
  localparam int unsigned RegTagValue = 3;

  localparam logic       KindPayload = 1'b0;
  localparam logic       KindStatus  = 1'b1;
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StBadLen    = 2'd1;
  localparam logic [1:0] StBadSum    = 2'd2;
  localparam logic [1:0] StBadTag    = 2'd3;

  localparam int unsigned AdlerBase    = 65521;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned EndCycles    = 20;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned CycleLimit   = 200000;

  typedef enum logic [1:0] {PhHeader, PhBody, PhHalted} parse_phase_e;
  typedef enum {FrGood, FrBadSum, FrBadTag, FrBadBoth, FrNoise} frame_mode_e;
  typedef enum {FillRand, FillOnes, FillZeros} fill_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [1:0]  st;
    logic        last;
    logic [31:0] flen;
  } frame_item_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic [7:0]                  in_byte_i = 8'h00;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic                        out_kind_o;
  logic [7:0]                  data_byte_o;
  logic [1:0]                  status_o;
  logic                        last_o;
  logic [lta_pkg::WordW-1:0]   frame_length_o;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [lta_pkg::AddrW-1:0]   paddr = '0;
  logic [lta_pkg::WordW-1:0]   pwdata = '0;
  logic [lta_pkg::WordW-1:0]   prdata;
  logic                        pready;

  length_tag_adler_frame_checker_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_kind_o     (out_kind_o),
    .data_byte_o    (data_byte_o),
    .status_o       (status_o),
    .last_o         (last_o),
    .frame_length_o (frame_length_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // register shadow, reset values
  lta_pkg::cfg_t cfg_q = '{min_len:   lta_pkg::MinLenRst,
                           max_len:   lta_pkg::MaxLenRst,
                           tag_len:   lta_pkg::TagLenRst,
                           tag_value: lta_pkg::TagValueRst};

  // frame parser state
  parse_phase_e parse_ph  = PhHeader;
  logic [31:0]  len_sr    = '0;
  logic [26:0]  byte_cnt  = '0;
  logic [31:0]  run_sum   = 32'h1;  // {high, low}
  logic         tag_good  = 1'b1;
  logic [31:0]  rx_sum    = '0;

  logic [7:0]   stream_bytes_q[$];
  frame_item_t  frame_results_q[$];

  int unsigned cyc = 0;
  int unsigned err_cnt = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // no random idling on either side while cyc[10:8] is 3
  wire idle_ok = (cyc[10:8] != 3'd3);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cyc <= cyc + 1;

  function automatic logic [31:0] adler_next(logic [31:0] cur, logic [7:0] b);
    int unsigned lo;
    int unsigned hi;
    lo = cur[15:0] + b;
    if (lo >= AdlerBase) lo -= AdlerBase;
    hi = cur[31:16] + lo;
    if (hi >= AdlerBase) hi -= AdlerBase;
    return {hi[15:0], lo[15:0]};
  endfunction

  task automatic parse_stream_byte(input logic [7:0] b);
    int unsigned tl;
    int unsigned idx;
    logic [7:0]  tag_b;
    frame_item_t r;
    tl = (cfg_q.tag_len > 4) ? 4 : cfg_q.tag_len;
    r = '0;
    case (parse_ph)
      PhHeader: begin
        len_sr = {len_sr[23:0], b};
        byte_cnt = 27'(byte_cnt + 1);
        if (byte_cnt == 4) begin
          byte_cnt = '0;
          if (len_sr > cfg_q.max_len || len_sr < cfg_q.min_len || len_sr < tl + 4) begin
            parse_ph = PhHalted;
            r.kind = KindStatus;
            r.st = StBadLen;
            r.last = 1'b1;
            r.flen = len_sr;
            frame_results_q.push_back(r);
          end else begin
            parse_ph = PhBody;
          end
        end
      end
      PhBody: begin
        idx = byte_cnt;
        if (idx < len_sr - 4) begin
          run_sum = adler_next(run_sum, b);
          if (idx < tl) begin
            tag_b = 8'(cfg_q.tag_value >> (8 * (tl - 1 - idx)));
            if (tag_b != b) tag_good = 1'b0;
          end else begin
            r.kind = KindPayload;
            r.data = b;
            r.flen = len_sr;
            frame_results_q.push_back(r);
          end
        end else begin
          rx_sum = {rx_sum[23:0], b};
        end
        byte_cnt = 27'(idx + 1);
        if (idx + 1 >= len_sr) begin
          r.kind = KindStatus;
          r.data = 8'h00;
          r.last = 1'b1;
          r.flen = len_sr;
          // checksum error wins over a wrong tag
          r.st = (run_sum != rx_sum) ? StBadSum : (!tag_good ? StBadTag : StOk);
          frame_results_q.push_back(r);
          parse_ph = PhHeader;
          len_sr = '0;
          byte_cnt = '0;
          run_sum = 32'h1;
          tag_good = 1'b1;
          rx_sum = '0;
        end
      end
      default: ;  // halted: swallow
    endcase
  endtask

  task automatic check_item(input frame_item_t got);
    frame_item_t want;
    if (frame_results_q.size() == 0) begin
      $error("unexpected item: kind %0d data %0h status %0d last %0d length %0h",
             got.kind, got.data, got.st, got.last, got.flen);
      err_cnt++;
    end else begin
      want = frame_results_q.pop_front();
      if (got.kind !== want.kind) begin
        $error("out_kind: expected %0d, got %0d", want.kind, got.kind);
        err_cnt++;
      end
      if (got.data !== want.data) begin
        $error("data_byte: expected %0h, got %0h", want.data, got.data);
        err_cnt++;
      end
      if (got.st !== want.st) begin
        $error("status: expected %0d, got %0d", want.st, got.st);
        err_cnt++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        err_cnt++;
      end
      if (got.flen !== want.flen) begin
        $error("frame_length: expected %0h, got %0h", want.flen, got.flen);
        err_cnt++;
      end
    end
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_byte_i  <= 8'h00;
    end else begin
      if (in_valid_i && in_ready_o) parse_stream_byte(in_byte_i);
      if (!in_valid_i || in_ready_o) begin
        if (stream_bytes_q.size() != 0 && !(idle_ok && $urandom_range(99) < 11)) begin
          in_valid_i <= 1'b1;
          in_byte_i  <= stream_bytes_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor and backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_seen   <= 0;
    end else begin
      if (out_valid_o && out_ready_i)
        check_item({out_kind_o, data_byte_o, status_o, last_o, frame_length_o});
      if (hold_seen != hold_req) begin
        hold_seen   <= hold_req;
        hold_left   <= HoldCycles;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(idle_ok && $urandom_range(99) < 11);
      end
    end
  end

  task automatic cfg_write(input int unsigned idx, input logic [31:0] val);
    logic [lta_pkg::AddrW-1:0] addr;
    addr = lta_pkg::AddrW'(idx * 4);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegMinLen:   cfg_q.min_len = val[26:0];
      RegMaxLen:   cfg_q.max_len = val[26:0];
      RegTagLen:   cfg_q.tag_len = val[2:0];
      RegTagValue: cfg_q.tag_value = val;
      default: ;
    endcase
  endtask

  // sampled on the falling edge so driver updates have settled
  task automatic wait_idle();
    while (stream_bytes_q.size() != 0 || in_valid_i || frame_results_q.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic queue_frame(input int unsigned plen, input frame_mode_e mode,
                             input fill_e fill);
    int unsigned tl;
    int unsigned flen;
    int unsigned bad_at;
    logic [31:0] sum;
    logic [7:0]  b;
    tl = (cfg_q.tag_len > 4) ? 4 : cfg_q.tag_len;
    flen = tl + plen + 4;
    bad_at = (tl != 0) ? $urandom_range(tl - 1) : 0;
    for (int i = 0; i < 4; i++) stream_bytes_q.push_back(8'(flen >> (24 - 8 * i)));
    sum = 32'h1;
    for (int i = 0; i < tl + plen; i++) begin
      if (i < tl) begin
        b = 8'(cfg_q.tag_value >> (8 * (tl - 1 - i)));
        if ((mode == FrBadTag || mode == FrBadBoth) && i == bad_at)
          b = b ^ 8'($urandom_range(255, 1));
      end else begin
        case (fill)
          FillOnes:  b = 8'hFF;
          FillZeros: b = 8'h00;
          default:   b = 8'($urandom);
        endcase
      end
      if (mode == FrNoise) b = 8'($urandom);
      sum = adler_next(sum, b);
      stream_bytes_q.push_back(b);
    end
    if (mode == FrBadSum || mode == FrBadBoth) sum = sum ^ (32'h1 << $urandom_range(31));
    else if (mode == FrNoise) sum = $urandom;
    for (int i = 0; i < 4; i++) stream_bytes_q.push_back(8'(sum >> (24 - 8 * i)));
  endtask

  task automatic run_phase(input logic [31:0] lo_len, input logic [31:0] hi_len,
                           input logic [2:0] tlen, input logic [31:0] tag,
                           input int unsigned budget, input bit with_hold);
    int unsigned tl;
    int unsigned lo;
    int unsigned hi;
    int unsigned plen;
    int unsigned queued;
    int unsigned r;
    frame_mode_e mode;
    fill_e       fill;
    wait_idle();
    cfg_write(RegMinLen, lo_len);
    cfg_write(RegMaxLen, hi_len);
    cfg_write(RegTagLen, {29'd0, tlen});
    cfg_write(RegTagValue, tag);
    tl = (tlen > 4) ? 4 : tlen;
    lo = (lo_len > tl + 4) ? lo_len : tl + 4;
    hi = (hi_len < lo + 36) ? hi_len : lo + 36;
    queued = 0;
    while (queued < budget) begin
      r = $urandom_range(99);
      mode = (r < 70) ? FrGood : (r < 80) ? FrBadSum : (r < 88) ? FrBadTag :
             (r < 92) ? FrBadBoth : FrNoise;
      r = $urandom_range(9);
      fill = (r == 0) ? FillOnes : (r == 1) ? FillZeros : FillRand;
      if (hi_len >= tl + 304 && $urandom_range(11) == 0) begin
        // long run of 0xFF pushes the low sum past the modulus
        plen = $urandom_range(300, 260);
        fill = FillOnes;
      end else begin
        plen = $urandom_range(hi, lo) - tl - 4;
      end
      queue_frame(plen, mode, fill);
      // header, tag, payload and checksum bytes
      queued += plen + tl + 8;
    end
    if (with_hold) hold_req++;
  endtask

  initial begin
    wait (cyc >= CycleLimit);
    $display("length_tag_adler_frame_checker_unit test failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, no tag: empty body, 0xFF payload, checksum error
    queue_frame(0, FrGood, FillRand);
    queue_frame(1, FrGood, FillOnes);
    queue_frame(2, FrBadSum, FillRand);
    wait_idle();
    cfg_write(RegTagLen, 32'd4);
    cfg_write(RegTagValue, 32'hA5C3_0F96);
    queue_frame(0, FrGood, FillRand);
    queue_frame(1, FrBadTag, FillZeros);
    queue_frame(0, FrBadBoth, FillRand);

    run_phase(0, 32'd1 << 26, 3'd0, 32'h0, 300, 1'b0);
    run_phase(0, 32'd1 << 26, 3'd4, 32'hFFFF_FFFF, 300, 1'b1);
    run_phase(20, 20, 3'd2, $urandom, 250, 1'b0);
    run_phase(5, 5, 3'd1, $urandom, 150, 1'b0);
    run_phase(8, 600, 3'd7, $urandom, 300, 1'b0);
    run_phase(10, 60, 3'd3, $urandom, 250, 1'b0);
    run_phase(0, 32'd1 << 26, 3'd5, 32'h0, 200, 1'b0);

    // header with the top bit set: invalid length, then the block halts
    wait_idle();
    stream_bytes_q.push_back(8'h80);
    stream_bytes_q.push_back(8'h00);
    stream_bytes_q.push_back(8'h00);
    stream_bytes_q.push_back(8'h05);
    repeat (6) stream_bytes_q.push_back(8'($urandom));

    wait_idle();
    repeat (EndCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("length_tag_adler_frame_checker_unit test passed");
    end else begin
      $display("length_tag_adler_frame_checker_unit test failed");
    end
    $finish;
  end

endmodule

FILE: length_tag_adler_frame_checker_unit.f
hdl/lta_pkg.sv
hdl/lta_apb_regs.sv
hdl/length_tag_adler_frame_checker_unit.sv
test/tb.sv
